// ----- rtl/disc_date_to_epoch_seconds_defines.svh -----
// Assertion macros used by the checker of the date converter.
`ifndef DISC_DATE_TO_EPOCH_SECONDS_DEFINES_SVH
`define DISC_DATE_TO_EPOCH_SECONDS_DEFINES_SVH

// Same-cycle implication, off while reset is asserted
`define DDES_ASSERT_IMP(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |-> (cons)) \
    else $error(msg);

// Next-cycle implication, off while reset is asserted
`define DDES_ASSERT_NXT(lbl, clk, rstn, ante, cons, msg) \
  lbl: assert property (@(posedge clk) disable iff (!(rstn)) (ante) |=> (cons)) \
    else $error(msg);

// Next-cycle implication that also runs through reset
`define DDES_ASSERT_NXT_ALWAYS(lbl, clk, ante, cons, msg) \
  lbl: assert property (@(posedge clk) (ante) |=> (cons)) \
    else $error(msg);

`endif

// ----- rtl/ddes_pkg.sv -----
`default_nettype none
package ddes_pkg;

  // Field widths
  localparam int unsigned BYTE_W    = 8;
  localparam int unsigned DAYS_W    = 17;  // days since 1970, up to year 2155
  localparam int unsigned HOUR_W    = 5;
  localparam int unsigned MINSEC_W  = 6;
  localparam int unsigned T1_W      = 21;  // days*24 + hour
  localparam int unsigned T2_W      = 27;  // minutes
  localparam int unsigned SECS_W    = 33;  // seconds

  // Calendar constants (year byte counts from 1900)
  localparam logic [BYTE_W-1:0] EPOCH_YEAR_OFS = 8'd70;
  localparam logic [BYTE_W-1:0] MONTH_FEB      = 8'd2;
  localparam logic [BYTE_W-1:0] MONTH_LAST     = 8'd12;
  localparam logic [BYTE_W-1:0] LEAP_DAY       = 8'd29;
  localparam logic [BYTE_W-1:0] HOUR_MAX       = 8'd23;
  localparam logic [BYTE_W-1:0] MINSEC_MAX     = 8'd59;
  localparam logic [6:0]        LEAPS_BEFORE_EPOCH = 7'd18;  // (69+3)/4
  localparam logic [DAYS_W-1:0] DAYS_PER_YEAR  = 17'd365;

  // Queue depth between front and back
  localparam int unsigned QUEUE_DEPTH_DEF = 2;

  // One classified item handed from front to back
  typedef struct packed {
    logic                ok;
    logic [DAYS_W-1:0]   days;
    logic [HOUR_W-1:0]   hour;
    logic [MINSEC_W-1:0] minute;
    logic [MINSEC_W-1:0] second;
  } ddes_item_t;

  // Length of a month in a common year, 0 for a bad month code
  function automatic logic [4:0] month_len(input logic [3:0] mon);
    logic [4:0] len;
    case (mon)
      4'd1, 4'd3, 4'd5, 4'd7, 4'd8, 4'd10, 4'd12: len = 5'd31;
      4'd4, 4'd6, 4'd9, 4'd11:                    len = 5'd30;
      4'd2:                                        len = 5'd28;
      default:                                     len = 5'd0;
    endcase
    return len;
  endfunction

  // Days in a common year before the first of the month
  function automatic logic [8:0] days_before_month(input logic [3:0] mon);
    logic [8:0] d;
    case (mon)
      4'd1:    d = 9'd0;
      4'd2:    d = 9'd31;
      4'd3:    d = 9'd59;
      4'd4:    d = 9'd90;
      4'd5:    d = 9'd120;
      4'd6:    d = 9'd151;
      4'd7:    d = 9'd181;
      4'd8:    d = 9'd212;
      4'd9:    d = 9'd243;
      4'd10:   d = 9'd273;
      4'd11:   d = 9'd304;
      4'd12:   d = 9'd334;
      default: d = 9'd0;
    endcase
    return d;
  endfunction

endpackage
`default_nettype wire

// ----- rtl/disc_date_to_epoch_seconds.sv -----
// Path: an accepted item passes the front register, the queue, then three multiply-add
//   stages for hours, minutes and seconds.
// Throughput: one item per cycle while out_ready is high; each back stage does one constant multiply-add.
// Reset: synchronous, active low; clears the valid bits and the queue count at once,
//   with no clearing pass. Payload registers are not reset.
`default_nettype none
module disc_date_to_epoch_seconds #(
  parameter int unsigned QUEUE_DEPTH = ddes_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic        clk,
  input  wire logic        rst_n,
  input  wire logic        in_valid,
  output logic             in_ready,
  input  wire logic [7:0]  in_year_since_1900,
  input  wire logic [7:0]  in_month_num,
  input  wire logic [7:0]  in_day_num,
  input  wire logic [7:0]  in_hour_num,
  input  wire logic [7:0]  in_minute_num,
  input  wire logic [7:0]  in_second_num,
  input  wire logic [7:0]  in_zone_offset,  // zone is not applied
  output logic             out_valid,
  input  wire logic        out_ready,
  output logic [32:0]      out_epoch_seconds,
  output logic             out_date_valid
);
  import ddes_pkg::*;

  logic       f_valid, f_ready;
  ddes_item_t f_item;
  logic       q_valid, q_ready;
  ddes_item_t q_item;

  // Check fields and count days
  ddes_front u_front (
    .clk                (clk),
    .rst_n              (rst_n),
    .in_valid           (in_valid),
    .in_ready           (in_ready),
    .in_year_since_1900 (in_year_since_1900),
    .in_month_num       (in_month_num),
    .in_day_num         (in_day_num),
    .in_hour_num        (in_hour_num),
    .in_minute_num      (in_minute_num),
    .in_second_num      (in_second_num),
    .item_valid         (f_valid),
    .item_ready         (f_ready),
    .item               (f_item)
  );

  // Decoupling queue
  ddes_queue #(
    .DEPTH (QUEUE_DEPTH)
  ) u_queue (
    .clk       (clk),
    .rst_n     (rst_n),
    .in_valid  (f_valid),
    .in_ready  (f_ready),
    .in_item   (f_item),
    .out_valid (q_valid),
    .out_ready (q_ready),
    .out_item  (q_item)
  );

  // Days to seconds
  ddes_back u_back (
    .clk               (clk),
    .rst_n             (rst_n),
    .in_valid          (q_valid),
    .in_ready          (q_ready),
    .in_item           (q_item),
    .out_valid         (out_valid),
    .out_ready         (out_ready),
    .out_epoch_seconds (out_epoch_seconds),
    .out_date_valid    (out_date_valid)
  );

endmodule
`default_nettype wire

// ----- rtl/ddes_front.sv -----
`default_nettype none
module ddes_front (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire logic [7:0]            in_year_since_1900,
  input  wire logic [7:0]            in_month_num,
  input  wire logic [7:0]            in_day_num,
  input  wire logic [7:0]            in_hour_num,
  input  wire logic [7:0]            in_minute_num,
  input  wire logic [7:0]            in_second_num,
  output logic                       item_valid,
  input  wire logic                  item_ready,
  output ddes_pkg::ddes_item_t       item
);
  import ddes_pkg::*;

  logic       leap;
  logic [4:0] mlen;
  logic       y_ok, m_ok, d_ok, t_ok, ok;
  logic [7:0] yoff;
  logic [6:0] leaps;
  logic [DAYS_W-1:0] days;
  ddes_item_t item_nxt;
  ddes_item_t item_r;
  logic       valid_r;

  // Field checks; leap years are the multiples of four (1900 is one)
  always_comb begin
    leap = (in_year_since_1900[1:0] == 2'b00);
    mlen = month_len(in_month_num[3:0]);
    y_ok = (in_year_since_1900 >= EPOCH_YEAR_OFS);
    m_ok = (in_month_num != 8'd0) && (in_month_num <= MONTH_LAST);
    d_ok = (in_day_num != 8'd0) &&
           ((in_day_num <= {3'd0, mlen}) ||
            ((in_month_num == MONTH_FEB) && (in_day_num == LEAP_DAY) && leap));
    t_ok = (in_hour_num <= HOUR_MAX) && (in_minute_num <= MINSEC_MAX) &&
           (in_second_num <= MINSEC_MAX);
    ok   = y_ok && m_ok && d_ok && t_ok;
  end

  // Day count since 1970-01-01
  always_comb begin
    yoff  = in_year_since_1900 - EPOCH_YEAR_OFS;
    leaps = 7'((9'(in_year_since_1900) + 9'd3) >> 2) - LEAPS_BEFORE_EPOCH;
    days  = 17'({9'd0, yoff}) * DAYS_PER_YEAR
          + 17'(leaps)
          + 17'(days_before_month(in_month_num[3:0]))
          + 17'(leap && (in_month_num > MONTH_FEB))
          + 17'(in_day_num) - 17'd1;
  end

  // Invalid items carry zeros so the back end yields zero by itself
  always_comb begin
    item_nxt.ok     = ok;
    item_nxt.days   = ok ? days : '0;
    item_nxt.hour   = ok ? in_hour_num[HOUR_W-1:0] : '0;
    item_nxt.minute = ok ? in_minute_num[MINSEC_W-1:0] : '0;
    item_nxt.second = ok ? in_second_num[MINSEC_W-1:0] : '0;
  end

  assign in_ready   = !valid_r || item_ready;
  assign item_valid = valid_r;
  assign item       = item_r;

  // Output register of the front
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      valid_r <= 1'b0;
    end else if (in_ready) begin
      valid_r <= in_valid;
    end
    if (in_ready && in_valid) begin
      item_r <= item_nxt;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ddes_queue.sv -----
`default_nettype none
module ddes_queue #(
  parameter int unsigned DEPTH = ddes_pkg::QUEUE_DEPTH_DEF
) (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire ddes_pkg::ddes_item_t  in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output ddes_pkg::ddes_item_t       out_item
);
  import ddes_pkg::*;

  localparam int unsigned PTR_W = (DEPTH > 1) ? $clog2(DEPTH) : 1;
  localparam int unsigned CNT_W = $clog2(DEPTH + 1);

  ddes_item_t       mem_r [DEPTH];
  logic [PTR_W-1:0] wr_ptr_r, rd_ptr_r;
  logic [CNT_W-1:0] cnt_r;
  logic             push, pop;

  assign in_ready  = (cnt_r != CNT_W'(DEPTH));
  assign out_valid = (cnt_r != '0);
  assign out_item  = mem_r[rd_ptr_r];
  assign push      = in_valid && in_ready;
  assign pop       = out_valid && out_ready;

  // Pointers wrap at the depth, count tracks fill
  always_ff @(posedge clk) begin
    if (!rst_n) begin
      wr_ptr_r <= '0;
      rd_ptr_r <= '0;
      cnt_r    <= '0;
    end else begin
      if (push) begin
        wr_ptr_r <= (wr_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : wr_ptr_r + PTR_W'(1);
      end
      if (pop) begin
        rd_ptr_r <= (rd_ptr_r == PTR_W'(DEPTH - 1)) ? '0 : rd_ptr_r + PTR_W'(1);
      end
      if (push && !pop) begin
        cnt_r <= cnt_r + CNT_W'(1);
      end else if (pop && !push) begin
        cnt_r <= cnt_r - CNT_W'(1);
      end
    end
    if (push) begin
      mem_r[wr_ptr_r] <= in_item;
    end
  end

endmodule
`default_nettype wire

// ----- rtl/ddes_back.sv -----
`default_nettype none
module ddes_back (
  input  wire logic                  clk,
  input  wire logic                  rst_n,
  input  wire logic                  in_valid,
  output logic                       in_ready,
  input  wire ddes_pkg::ddes_item_t  in_item,
  output logic                       out_valid,
  input  wire logic                  out_ready,
  output logic [32:0]                out_epoch_seconds,
  output logic                       out_date_valid
);
  import ddes_pkg::*;

  logic                v1_r, v2_r, v3_r;
  logic                rdy1, rdy2, rdy3;
  logic                ok1_r, ok2_r, ok3_r;
  logic [T1_W-1:0]     t1_r, t1_nxt;
  logic [T2_W-1:0]     t2_r, t2_nxt;
  logic [SECS_W-1:0]   t3_r, t3_nxt;
  logic [MINSEC_W-1:0] min1_r, sec1_r, sec2_r;

  // A stage moves when it is empty or the next one moves
  assign rdy3     = !v3_r || out_ready;
  assign rdy2     = !v2_r || rdy3;
  assign rdy1     = !v1_r || rdy2;
  assign in_ready = rdy1;

  // One constant multiply and add per stage
  assign t1_nxt = T1_W'(in_item.days) * T1_W'(24) + T1_W'(in_item.hour);
  assign t2_nxt = T2_W'(t1_r) * T2_W'(60) + T2_W'(min1_r);
  assign t3_nxt = SECS_W'(t2_r) * SECS_W'(60) + SECS_W'(sec2_r);

  always_ff @(posedge clk) begin
    if (!rst_n) begin
      v1_r <= 1'b0;
      v2_r <= 1'b0;
      v3_r <= 1'b0;
    end else begin
      if (rdy1) v1_r <= in_valid;
      if (rdy2) v2_r <= v1_r;
      if (rdy3) v3_r <= v2_r;
    end
    // hours
    if (rdy1 && in_valid) begin
      t1_r   <= t1_nxt;
      min1_r <= in_item.minute;
      sec1_r <= in_item.second;
      ok1_r  <= in_item.ok;
    end
    // minutes
    if (rdy2 && v1_r) begin
      t2_r   <= t2_nxt;
      sec2_r <= sec1_r;
      ok2_r  <= ok1_r;
    end
    // seconds, output register
    if (rdy3 && v2_r) begin
      t3_r  <= t3_nxt;
      ok3_r <= ok2_r;
    end
  end

  assign out_valid         = v3_r;
  assign out_epoch_seconds = t3_r;
  assign out_date_valid    = ok3_r;

endmodule
`default_nettype wire

// ----- rtl/ddes_checker.sv -----
`default_nettype none
`include "disc_date_to_epoch_seconds_defines.svh"
module ddes_checker (
  input wire logic        clk,
  input wire logic        rst_n,
  input wire logic        out_valid,
  input wire logic        out_ready,
  input wire logic [32:0] out_epoch_seconds,
  input wire logic        out_date_valid
);

  // A rejected date always reads as zero seconds
  `DDES_ASSERT_IMP(a_bad_is_zero, clk, rst_n, out_valid && !out_date_valid, out_epoch_seconds == 33'd0, "invalid date with nonzero seconds")

  // Good dates stay within the range of years 1970 to 2155
  `DDES_ASSERT_IMP(a_secs_range, clk, rst_n, out_valid && out_date_valid, out_epoch_seconds < 33'd5900000000, "seconds out of range")

  // No result right after reset
  `DDES_ASSERT_NXT_ALWAYS(a_reset_empty, clk, !rst_n, !out_valid, "result offered after reset")

  // A stalled result holds
  `DDES_ASSERT_NXT(a_out_hold, clk, rst_n, out_valid && !out_ready, out_valid && $stable(out_epoch_seconds) && $stable(out_date_valid), "stalled result changed")

endmodule

bind disc_date_to_epoch_seconds ddes_checker u_ddes_checker (
  .clk               (clk),
  .rst_n             (rst_n),
  .out_valid         (out_valid),
  .out_ready         (out_ready),
  .out_epoch_seconds (out_epoch_seconds),
  .out_date_valid    (out_date_valid)
);
`default_nettype wire
